// ===== rtl/lis_pkg.sv =====
package lis_pkg;

    localparam int COMP_W  = 8;
    localparam int COEF_W  = 16;
    localparam int LUMA_W  = 24;
    localparam int INDEX_W = 6;
    localparam int N_COMP  = 3;

    typedef logic [1:0] t_step;

    localparam t_step STEP_RED   = 2'd0;
    localparam t_step STEP_GREEN = 2'd1;
    localparam t_step STEP_BLUE  = 2'd2;

    // Rec.709 weights in Q16, they sum to 65536
    localparam logic [COEF_W-1:0] COEF_RED   = 16'd13933;
    localparam logic [COEF_W-1:0] COEF_GREEN = 16'd46871;
    localparam logic [COEF_W-1:0] COEF_BLUE  = 16'd4732;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [LUMA_W-1:0]  luma;
    } t_entry;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MAC   = 6'b000010,
        S_SCAN  = 6'b000100,
        S_PLACE = 6'b001000,
        S_EMRD  = 6'b010000,
        S_EMLD  = 6'b100000
    } t_state;

endpackage

// ===== rtl/lis_pixel_if.sv =====
interface lis_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [lis_pkg::COMP_W-1:0] red;
    logic [lis_pkg::COMP_W-1:0] green;
    logic [lis_pkg::COMP_W-1:0] blue;
    logic                       final_pixel;

    modport source (output valid, red, green, blue, final_pixel, input ready);
    modport sink (input valid, red, green, blue, final_pixel, output ready);
endinterface

// ===== rtl/lis_result_if.sv =====
interface lis_result_if;
    logic                        valid;
    logic                        ready;
    logic [lis_pkg::INDEX_W-1:0] pixel_index;
    logic [lis_pkg::LUMA_W-1:0]  luma;
    logic                        end_of_run;

    modport source (output valid, pixel_index, luma, end_of_run, input ready);
    modport sink (input valid, pixel_index, luma, end_of_run, output ready);
endinterface

// ===== rtl/lis_luma_mac.sv =====
module lis_luma_mac (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_first,
    input  logic [lis_pkg::COMP_W-1:0]  i_comp,
    input  logic [lis_pkg::COEF_W-1:0]  i_coef,
    output logic [lis_pkg::LUMA_W-1:0]  o_luma
);

    logic [lis_pkg::LUMA_W-1:0] r_acc;
    logic [lis_pkg::LUMA_W-1:0] w_prod;

    assign w_prod = lis_pkg::LUMA_W'(i_comp * i_coef);

    // first term loads, later terms accumulate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= i_first ? w_prod : r_acc + w_prod;
        end
    end

    assign o_luma = r_acc;

endmodule

// ===== rtl/luma_index_sorter_top.sv =====
// Channel   Port    Direction  Transaction
// pixel     i_pix   sink       one RGB pixel, final_pixel closes the set
// result    o_res   source     one stored pixel index and luma, in ascending luma order
//
// A pixel runs its red, green and blue terms through the shared multiply-accumulate
// unit (S_MAC), shifts each stored entry with a larger luma up one slot (S_SCAN), up
// to MAX_PIXELS - 1 of them, then is written. ready is high only between pixels.
// A pixel that finds the store full is dropped after its multiply-accumulate steps.
// Results follow a final pixel, one store read each (S_EMRD, then S_EMLD, which waits
// while the result side stalls) through the single read port. Reset clears the pixel
// count and the sequencer; the store keeps its contents, only this set's entries are read.
module luma_index_sorter_top #(
    parameter int MAX_PIXELS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lis_pixel_if.sink     i_pix,
    lis_result_if.source  o_res
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = $clog2(MAX_PIXELS + 1);

    lis_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_pos, n_pos;
    logic [AW-1:0]   r_k, n_k;
    lis_pkg::t_step  r_step, n_step;

    logic [lis_pkg::COMP_W-1:0] r_red, r_green, r_blue;
    logic                       r_last;

    lis_pkg::t_entry r_mem [MAX_PIXELS];
    lis_pkg::t_entry r_rd_data;
    lis_pkg::t_entry w_wr_data;
    lis_pkg::t_entry w_new;
    logic            w_we;
    logic [AW-1:0]   w_wr_addr;
    logic [AW-1:0]   w_rd_addr;

    logic                       w_mac_en;
    logic [lis_pkg::COMP_W-1:0] w_comp;
    logic [lis_pkg::COEF_W-1:0] w_coef;
    logic [lis_pkg::LUMA_W-1:0] w_luma;

    logic                        r_out_valid;
    lis_pkg::t_entry             r_out;
    logic                        r_out_end;
    logic                        w_load;
    logic                        w_accept;
    logic [AW-1:0]               w_last_k;

    assign w_accept = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == lis_pkg::S_IDLE);

    always_comb begin
        case (r_step)
            lis_pkg::STEP_RED: begin
                w_comp = r_red;
                w_coef = lis_pkg::COEF_RED;
            end
            lis_pkg::STEP_GREEN: begin
                w_comp = r_green;
                w_coef = lis_pkg::COEF_GREEN;
            end
            lis_pkg::STEP_BLUE: begin
                w_comp = r_blue;
                w_coef = lis_pkg::COEF_BLUE;
            end
            default: begin
                w_comp = '0;
                w_coef = '0;
            end
        endcase
    end

    assign w_mac_en = (r_state == lis_pkg::S_MAC);

    lis_luma_mac u_mac (
        .i_clk   (i_clk),
        .i_en    (w_mac_en),
        .i_first (r_step == lis_pkg::STEP_RED),
        .i_comp  (w_comp),
        .i_coef  (w_coef),
        .o_luma  (w_luma)
    );

    assign w_new.index = lis_pkg::INDEX_W'(r_count);
    assign w_new.luma  = w_luma;
    assign w_last_k    = AW'(r_count - CW'(1));
    assign w_load      = (r_state == lis_pkg::S_EMLD) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_k       = r_k;
        n_step    = r_step;
        w_we      = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = w_new;
        w_rd_addr = r_k;
        case (r_state)
            lis_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_step  = lis_pkg::STEP_RED;
                    n_state = lis_pkg::S_MAC;
                end
            end
            lis_pkg::S_MAC: begin
                n_step = r_step + 2'd1;
                if (r_step == lis_pkg::STEP_BLUE) begin
                    if (r_count < CW'(MAX_PIXELS)) begin
                        n_pos = AW'(r_count);
                        if (r_count == '0) begin
                            n_state = lis_pkg::S_PLACE;
                        end else begin
                            w_rd_addr = w_last_k;
                            n_state   = lis_pkg::S_SCAN;
                        end
                    end else if (r_last) begin
                        n_k     = '0;
                        n_state = lis_pkg::S_EMRD;
                    end else begin
                        n_state = lis_pkg::S_IDLE;
                    end
                end
            end
            lis_pkg::S_SCAN: begin
                w_we = 1'b1;
                if (r_rd_data.luma > w_luma) begin
                    // shift the larger entry up one slot and look below
                    w_wr_data = r_rd_data;
                    n_pos     = r_pos - AW'(1);
                    w_rd_addr = r_pos - AW'(2);
                    if (r_pos == AW'(1)) begin
                        n_state = lis_pkg::S_PLACE;
                    end
                end else begin
                    n_count = r_count + CW'(1);
                    n_k     = '0;
                    n_state = r_last ? lis_pkg::S_EMRD : lis_pkg::S_IDLE;
                end
            end
            lis_pkg::S_PLACE: begin
                w_we    = 1'b1;
                n_count = r_count + CW'(1);
                n_k     = '0;
                n_state = r_last ? lis_pkg::S_EMRD : lis_pkg::S_IDLE;
            end
            lis_pkg::S_EMRD: begin
                n_state = lis_pkg::S_EMLD;
            end
            lis_pkg::S_EMLD: begin
                // hold the read address until the output register frees up
                if (w_load) begin
                    if (r_k == w_last_k) begin
                        n_count = '0;
                        n_state = lis_pkg::S_IDLE;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = lis_pkg::S_EMRD;
                    end
                end
            end
            default: begin
                n_state = lis_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lis_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_k    <= n_k;
        r_step <= n_step;
        if (w_accept) begin
            r_red   <= i_pix.red;
            r_green <= i_pix.green;
            r_blue  <= i_pix.blue;
            r_last  <= i_pix.final_pixel;
        end
        if (w_load) begin
            r_out     <= r_rd_data;
            r_out_end <= (r_k == w_last_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.pixel_index = r_out.index;
    assign o_res.luma        = r_out.luma;
    assign o_res.end_of_run  = r_out_end;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_PIXELS  = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 200;
    localparam int MAX_WAIT    = 12;
    localparam int TARGET_PIX  = 480;

    typedef struct {
        logic [lis_pkg::COMP_W-1:0] red;
        logic [lis_pkg::COMP_W-1:0] green;
        logic [lis_pkg::COMP_W-1:0] blue;
        logic                       final_pixel;
    } t_pixel;

    typedef struct {
        logic [lis_pkg::INDEX_W-1:0] pixel_index;
        logic [lis_pkg::LUMA_W-1:0]  luma;
        logic                        end_of_run;
    } t_ranked;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lis_pixel_if  pix ();
    lis_result_if res ();

    luma_index_sorter_top #(
        .MAX_PIXELS(MAX_PIXELS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix),
        .o_res  (res)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stimulus and predictor state
    t_pixel                      pixel_queue[$];
    t_ranked                     ranked_queue[$];
    logic [lis_pkg::LUMA_W-1:0]  sorted_luma[MAX_PIXELS];
    logic [lis_pkg::INDEX_W-1:0] sorted_index[MAX_PIXELS];
    int                          set_count;

    // Handshake bookkeeping shared between the edge processes
    bit          pix_sent;
    bit          res_taken;
    bit          pix_busy;
    bit          pix_burst;
    bit          res_burst;
    int unsigned pix_gap;
    int unsigned res_stall;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Pick a wait from 0 to MAX_WAIT; now and then flip into or out of a no-wait stretch.
    task automatic draw_wait(inout bit burst, output int unsigned cycles);
        if ($urandom_range(0, 15) == 0) begin
            burst = ~burst;
        end
        cycles = burst ? 0 : $urandom_range(0, MAX_WAIT);
    endtask

    // Insert one accepted pixel into the sorted set; on the last pixel, queue the run.
    function automatic void record_pixel(input t_pixel p);
        int unsigned                weighted;
        logic [lis_pkg::LUMA_W-1:0] y;
        int                         slot;
        weighted = 32'(p.red) * 32'(lis_pkg::COEF_RED)
                 + 32'(p.green) * 32'(lis_pkg::COEF_GREEN)
                 + 32'(p.blue) * 32'(lis_pkg::COEF_BLUE);
        y = lis_pkg::LUMA_W'(weighted);
        if (set_count < MAX_PIXELS) begin
            slot = set_count;
            // ties stay behind earlier pixels
            while (slot > 0 && sorted_luma[slot-1] > y) begin
                sorted_luma[slot]  = sorted_luma[slot-1];
                sorted_index[slot] = sorted_index[slot-1];
                slot--;
            end
            sorted_luma[slot]  = y;
            sorted_index[slot] = lis_pkg::INDEX_W'(set_count);
            set_count++;
        end
        if (p.final_pixel) begin
            for (int k = 0; k < set_count; k++) begin
                ranked_queue.push_back('{sorted_index[k], sorted_luma[k], k == set_count - 1});
            end
            set_count = 0;
        end
    endfunction

    function automatic logic [lis_pkg::COMP_W-1:0] pick_comp();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return lis_pkg::COMP_W'($urandom);
        endcase
    endfunction

    // Queue one set of n pixels; returns how many of them the store can hold.
    function automatic int add_set(input int n, input bit use_palette);
        t_pixel palette[4];
        t_pixel p;
        for (int k = 0; k < 4; k++) begin
            palette[k] = '{pick_comp(), pick_comp(), pick_comp(), 1'b0};
        end
        for (int k = 0; k < n; k++) begin
            if (use_palette) begin
                p = palette[$urandom_range(0, 3)];
            end else begin
                p = '{pick_comp(), pick_comp(), pick_comp(), 1'b0};
            end
            p.final_pixel = (k == n - 1);
            pixel_queue.push_back(p);
        end
        return (n < MAX_PIXELS) ? n : MAX_PIXELS;
    endfunction

    // Acceptance, prediction and result checking at the rising edge
    always @(posedge i_clk) begin : edge_sample
        t_ranked want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (!i_rst_n) begin
            pix_sent  <= 1'b0;
            res_taken <= 1'b0;
        end else begin
            pix_sent  <= pix.valid && pix.ready;
            res_taken <= res.valid && res.ready;
            if (pix.valid && pix.ready) begin
                record_pixel('{pix.red, pix.green, pix.blue, pix.final_pixel});
            end
            if (res.valid && res.ready) begin
                if (ranked_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result index %0d luma %0d",
                                              res.pixel_index, res.luma));
                end else begin
                    want = ranked_queue.pop_front();
                    if (res.pixel_index !== want.pixel_index) begin
                        report_mismatch($sformatf("pixel_index %0d, want %0d",
                                                  res.pixel_index, want.pixel_index));
                    end
                    if (res.luma !== want.luma) begin
                        report_mismatch($sformatf("luma %0d, want %0d (index %0d)",
                                                  res.luma, want.luma, want.pixel_index));
                    end
                    if (res.end_of_run !== want.end_of_run) begin
                        report_mismatch($sformatf("end_of_run %0b, want %0b (index %0d)",
                                                  res.end_of_run, want.end_of_run,
                                                  want.pixel_index));
                    end
                end
            end
        end
    end

    // Pixel driver: present the next queued pixel after its drawn gap, hold until taken
    always @(negedge i_clk) begin : pixel_driver
        t_pixel nxt;
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
        end else begin
            if (pix_sent) begin
                pix_busy = 1'b0;
            end
            if (!pix_busy) begin
                if (pix_gap > 0) begin
                    pix_gap--;
                    pix.valid <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    nxt = pixel_queue.pop_front();
                    pix.red         <= nxt.red;
                    pix.green       <= nxt.green;
                    pix.blue        <= nxt.blue;
                    pix.final_pixel <= nxt.final_pixel;
                    pix.valid       <= 1'b1;
                    pix_busy = 1'b1;
                    draw_wait(pix_burst, pix_gap);
                end else begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // Result side: stall after each transaction, and now and then while idle
    always @(negedge i_clk) begin : result_ready
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res_taken || (res_stall == 0 && $urandom_range(0, 15) == 0)) begin
                draw_wait(res_burst, res_stall);
            end
            if (res_stall > 0) begin
                res_stall--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int   stored;
        int   n;
        pix.valid       = 1'b0;
        pix.red         = '0;
        pix.green       = '0;
        pix.blue        = '0;
        pix.final_pixel = 1'b0;
        res.ready       = 1'b0;

        // single-pixel sets at both ends of the luma range
        pixel_queue.push_back('{8'd0, 8'd0, 8'd0, 1'b1});
        pixel_queue.push_back('{8'd255, 8'd255, 8'd255, 1'b1});
        // primaries, extremes and repeated colors for tie order
        pixel_queue.push_back('{8'd255, 8'd0, 8'd0, 1'b0});
        pixel_queue.push_back('{8'd0, 8'd255, 8'd0, 1'b0});
        pixel_queue.push_back('{8'd0, 8'd0, 8'd255, 1'b0});
        pixel_queue.push_back('{8'd0, 8'd0, 8'd0, 1'b0});
        pixel_queue.push_back('{8'd255, 8'd255, 8'd255, 1'b0});
        pixel_queue.push_back('{8'd10, 8'd20, 8'd30, 1'b0});
        pixel_queue.push_back('{8'd128, 8'd128, 8'd128, 1'b0});
        pixel_queue.push_back('{8'd10, 8'd20, 8'd30, 1'b0});
        pixel_queue.push_back('{8'd0, 8'd0, 8'd0, 1'b1});
        // falling luma: every new pixel shifts the whole store
        pixel_queue.push_back('{8'd200, 8'd200, 8'd200, 1'b0});
        pixel_queue.push_back('{8'd150, 8'd150, 8'd150, 1'b0});
        pixel_queue.push_back('{8'd100, 8'd100, 8'd100, 1'b0});
        pixel_queue.push_back('{8'd50, 8'd50, 8'd50, 1'b0});
        pixel_queue.push_back('{8'd0, 8'd0, 8'd1, 1'b1});
        stored = 16;

        // store exactly full, final pixel dropped when full, and a longer overflow
        stored += add_set(MAX_PIXELS, 1'b0);
        stored += add_set(MAX_PIXELS + 1, 1'b1);
        stored += add_set(MAX_PIXELS + 6, 1'b0);

        while (stored < TARGET_PIX) begin
            if ($urandom_range(0, 29) == 0) begin
                n = $urandom_range(MAX_PIXELS - 4, MAX_PIXELS + 4);
            end else begin
                n = $urandom_range(1, 12);
            end
            stored += add_set(n, $urandom_range(0, 2) == 0);
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pixel_queue.size() != 0 || pix_busy) @(posedge i_clk);
        while (ranked_queue.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lis_pkg.sv
rtl/lis_pixel_if.sv
rtl/lis_result_if.sv
rtl/lis_luma_mac.sv
rtl/luma_index_sorter_top.sv
sim/tb_top.sv
